// ===== hw/rtl/cpu_alu_8bit_with_flags_assert.svh =====
// ----------------------------------------------------------------------------
// ALU assertion macros
// Clocked assertion shorthands for the 8-bit ALU; reset disables each check.
// ----------------------------------------------------------------------------
`ifndef CPU_ALU_8BIT_WITH_FLAGS_ASSERT_SVH
`define CPU_ALU_8BIT_WITH_FLAGS_ASSERT_SVH

// same-cycle implication
`define CALU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CALU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/calu_pkg.sv =====
// ----------------------------------------------------------------------------
// ALU package
// Command codes, flag positions and widths of the 8-bit ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package calu_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned CmdW   = 5;
  localparam int unsigned FlagW  = 4;

  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD  = 5'd0,
    CMD_ADC  = 5'd1,
    CMD_SUB  = 5'd2,
    CMD_SBC  = 5'd3,
    CMD_AND  = 5'd4,
    CMD_OR   = 5'd5,
    CMD_XOR  = 5'd6,
    CMD_CP   = 5'd7,
    CMD_INC  = 5'd8,
    CMD_DEC  = 5'd9,
    CMD_RLC  = 5'd10,
    CMD_RL   = 5'd11,
    CMD_RRC  = 5'd12,
    CMD_RR   = 5'd13,
    CMD_CPL  = 5'd14,
    CMD_CCF  = 5'd15,
    CMD_SCF  = 5'd16,
    CMD_LOAD = 5'd17
  } cmd_e;

endpackage

// ===== hw/rtl/cpu_alu_8bit_with_flags.sv =====
// ----------------------------------------------------------------------------
// 8-bit ALU with flags
// Accumulator ALU with zero, subtract, half-carry and carry flags.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry a word of command_i and
// operand_i. Output channel: out_valid_o / out_stall_i carry a word of
// result_o and the four flag bits after the operation.
// An accepted word is held in the input register; from there it runs against
// the accumulator and flags and loads the result register, which offers the
// result on result_o and the flag outputs.
// Throughput is one word per cycle while out_stall_i is low; the accumulator
// and flag registers update in the same edge that loads the result register.
// When the receiver stalls, the result register holds its word, the input
// register holds the next one, and in_stall_o rises once both are full.
// Reset clears the accumulator, all flags and both valid bits.
// Commands 18 to 31 change nothing and return the accumulator and flags.
`timescale 1ns / 1ps

`include "cpu_alu_8bit_with_flags_assert.svh"

module cpu_alu_8bit_with_flags
  import calu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CmdW-1:0]   command_i,
  input  logic [DataW-1:0]  operand_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [DataW-1:0]  result_o,
  output logic              zero_flag_o,
  output logic              subtract_flag_o,
  output logic              half_carry_flag_o,
  output logic              carry_flag_o
);

  logic              s1_valid_q;
  logic [CmdW-1:0]   s1_cmd_q;
  logic [DataW-1:0]  s1_op_q;
  logic              out_valid_q;
  logic [DataW-1:0]  res_q;
  logic [FlagW-1:0]  oflags_q;
  logic [DataW-1:0]  acc_q, acc_d;
  logic [FlagW-1:0]  flags_q, flags_d;
  logic [DataW-1:0]  res_d;

  logic              out_load;
  logic              adv;
  logic              in_take;

  logic              cin_a, cin_s, cy;
  logic [DataW:0]    add_sum, sub_dif;
  logic [4:0]        add_half, sub_half;
  logic [DataW-1:0]  op;

  assign out_load   = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    op       = s1_op_q;
    cy       = flags_q[FlagC];
    cin_a    = (s1_cmd_q == CMD_ADC) && cy;
    cin_s    = (s1_cmd_q == CMD_SBC) && cy;
    add_sum  = {1'b0, acc_q} + {1'b0, op} + {{DataW{1'b0}}, cin_a};
    add_half = {1'b0, acc_q[3:0]} + {1'b0, op[3:0]} + {4'd0, cin_a};
    sub_dif  = {1'b0, acc_q} - {1'b0, op} - {{DataW{1'b0}}, cin_s};
    sub_half = {1'b0, acc_q[3:0]} - {1'b0, op[3:0]} - {4'd0, cin_s};
    res_d    = acc_q;
    acc_d    = acc_q;
    flags_d  = flags_q;
    unique case (s1_cmd_q) inside
      CMD_ADD, CMD_ADC: begin
        res_d   = add_sum[DataW-1:0];
        acc_d   = res_d;
        flags_d = {res_d == '0, 1'b0, add_half[4], add_sum[DataW]};
      end
      CMD_SUB, CMD_SBC: begin
        res_d   = sub_dif[DataW-1:0];
        acc_d   = res_d;
        flags_d = {res_d == '0, 1'b1, sub_half[4], sub_dif[DataW]};
      end
      CMD_CP: begin
        flags_d = {sub_dif[DataW-1:0] == '0, 1'b1, sub_half[4], sub_dif[DataW]};
      end
      CMD_AND: begin
        res_d   = acc_q & op;
        acc_d   = res_d;
        flags_d = {res_d == '0, 1'b0, 1'b1, 1'b0};
      end
      CMD_OR: begin
        res_d   = acc_q | op;
        acc_d   = res_d;
        flags_d = {res_d == '0, 3'b000};
      end
      CMD_XOR: begin
        res_d   = acc_q ^ op;
        acc_d   = res_d;
        flags_d = {res_d == '0, 3'b000};
      end
      CMD_INC: begin
        res_d   = op + 8'd1;
        flags_d = {res_d == '0, 1'b0, op[3:0] == 4'hF, cy};
      end
      CMD_DEC: begin
        res_d   = op - 8'd1;
        flags_d = {res_d == '0, 1'b1, op[3:0] == 4'h0, cy};
      end
      CMD_RLC: begin
        res_d   = {op[DataW-2:0], op[DataW-1]};
        flags_d = {res_d == '0, 2'b00, op[DataW-1]};
      end
      CMD_RL: begin
        res_d   = {op[DataW-2:0], cy};
        flags_d = {res_d == '0, 2'b00, op[DataW-1]};
      end
      CMD_RRC: begin
        res_d   = {op[0], op[DataW-1:1]};
        flags_d = {res_d == '0, 2'b00, op[0]};
      end
      CMD_RR: begin
        res_d   = {cy, op[DataW-1:1]};
        flags_d = {res_d == '0, 2'b00, op[0]};
      end
      CMD_CPL: begin
        res_d   = ~acc_q;
        acc_d   = res_d;
        flags_d = {flags_q[FlagZ], 1'b1, 1'b1, cy};
      end
      CMD_CCF: begin
        flags_d = {flags_q[FlagZ], 2'b00, !cy};
      end
      CMD_SCF: begin
        flags_d = {flags_q[FlagZ], 2'b00, 1'b1};
      end
      CMD_LOAD: begin
        res_d   = op;
        acc_d   = op;
      end
      default: begin
        res_d   = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      flags_q     <= '0;
    end else begin
      if (!s1_valid_q || out_load) begin
        s1_valid_q <= in_take;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (adv) begin
        acc_q   <= acc_d;
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q <= command_i;
      s1_op_q  <= operand_i;
    end
    if (adv) begin
      res_q    <= res_d;
      oflags_q <= flags_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_o          = res_q;
  assign zero_flag_o       = oflags_q[FlagZ];
  assign subtract_flag_o   = oflags_q[FlagN];
  assign half_carry_flag_o = oflags_q[FlagH];
  assign carry_flag_o      = oflags_q[FlagC];

  `CALU_ASSERT_NEXT(a_acc_hold, !adv, $stable(acc_q) && $stable(flags_q),
    "accumulator or flags changed without an advancing word")
  `CALU_ASSERT_NEXT(a_adv_fills_out, adv, out_valid_q,
    "advanced word did not reach the result register")
  `CALU_ASSERT_NOW(a_no_adv_stalled, out_valid_q && out_stall_i, !adv,
    "word advanced into a stalled result register")
  `CALU_ASSERT_NEXT(a_sub_flag,
    adv && (s1_cmd_q == CMD_SUB || s1_cmd_q == CMD_SBC || s1_cmd_q == CMD_CP),
    flags_q[FlagN] && subtract_flag_o, "subtract flag not set by a subtract")
  `CALU_ASSERT_NEXT(a_cp_keeps_acc, adv && s1_cmd_q == CMD_CP,
    $stable(acc_q) && result_o == acc_q, "compare altered the accumulator")

endmodule

// ===== sim/cpu_alu_8bit_with_flags_test.sv =====
// ----------------------------------------------------------------------------
// 8-bit ALU with flags testbench
// Queue-fed driver and clocked monitor. Each accepted word runs through a
// behavioral accumulator and flag model. Each result word is checked against
// the oldest prediction. Idling on both sides shifts over three phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpu_alu_8bit_with_flags_test;
  import calu_pkg::*;

  localparam int unsigned RandomWords = 1450;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportMax   = 10;

  localparam logic [CmdW-1:0] CmdUnknownLo = CMD_LOAD + 5'd1;
  localparam logic [CmdW-1:0] CmdUnknownHi = '1;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [DataW-1:0] operand;
  } alu_word_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             zero;
    logic             subtract;
    logic             half_carry;
    logic             carry;
  } alu_outcome_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CmdW-1:0]   command_i = '0;
  logic [DataW-1:0]  operand_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DataW-1:0]  result_o;
  logic              zero_flag_o;
  logic              subtract_flag_o;
  logic              half_carry_flag_o;
  logic              carry_flag_o;

  alu_word_t    pending_words[$];
  alu_outcome_t expected_outcomes[$];

  logic [DataW-1:0] acc_model = '0;
  logic             z_model = 1'b0;
  logic             n_model = 1'b0;
  logic             h_model = 1'b0;
  logic             c_model = 1'b0;

  int unsigned total_words = 0;
  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  alu_word_t    next_word;
  alu_outcome_t want;
  alu_outcome_t got;

  cpu_alu_8bit_with_flags dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .operand_i         (operand_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .result_o          (result_o),
    .zero_flag_o       (zero_flag_o),
    .subtract_flag_o   (subtract_flag_o),
    .half_carry_flag_o (half_carry_flag_o),
    .carry_flag_o      (carry_flag_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic alu_outcome_t alu_execute(input logic [CmdW-1:0] cmd,
                                               input logic [DataW-1:0] op);
    logic [DataW:0]   wide;
    logic [4:0]       nib;
    logic [DataW-1:0] a;
    logic [DataW-1:0] res;
    logic             cin;
    alu_outcome_t     out;
    a   = acc_model;
    res = a;
    cin = c_model;
    case (cmd)
      CMD_ADD, CMD_ADC: begin
        if (cmd == CMD_ADD) cin = 1'b0;
        wide = {1'b0, a} + {1'b0, op} + {{DataW{1'b0}}, cin};
        nib  = {1'b0, a[3:0]} + {1'b0, op[3:0]} + {4'b0, cin};
        res  = wide[DataW-1:0];
        z_model = (res == '0);
        n_model = 1'b0;
        h_model = nib[4];
        c_model = wide[DataW];
        acc_model = res;
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        if (cmd != CMD_SBC) cin = 1'b0;
        wide = {1'b0, a} - {1'b0, op} - {{DataW{1'b0}}, cin};
        nib  = {1'b0, a[3:0]} - {1'b0, op[3:0]} - {4'b0, cin};
        z_model = (wide[DataW-1:0] == '0);
        n_model = 1'b1;
        h_model = nib[4];
        c_model = wide[DataW];
        if (cmd != CMD_CP) begin
          res = wide[DataW-1:0];
          acc_model = res;
        end
      end
      CMD_AND, CMD_OR, CMD_XOR: begin
        if (cmd == CMD_AND) res = a & op;
        else if (cmd == CMD_OR) res = a | op;
        else res = a ^ op;
        z_model = (res == '0);
        n_model = 1'b0;
        h_model = (cmd == CMD_AND);
        c_model = 1'b0;
        acc_model = res;
      end
      CMD_INC, CMD_DEC: begin
        res = (cmd == CMD_INC) ? op + 8'd1 : op - 8'd1;
        z_model = (res == '0);
        n_model = (cmd == CMD_DEC);
        h_model = (cmd == CMD_INC) ? (op[3:0] == 4'hF) : (op[3:0] == 4'h0);
      end
      CMD_RLC, CMD_RL, CMD_RRC, CMD_RR: begin
        case (cmd)
          CMD_RLC: res = {op[6:0], op[7]};
          CMD_RL:  res = {op[6:0], cin};
          CMD_RRC: res = {op[0], op[7:1]};
          default: res = {cin, op[7:1]};
        endcase
        z_model = (res == '0);
        n_model = 1'b0;
        h_model = 1'b0;
        c_model = (cmd == CMD_RLC || cmd == CMD_RL) ? op[7] : op[0];
      end
      CMD_CPL: begin
        res = ~a;
        acc_model = res;
        n_model = 1'b1;
        h_model = 1'b1;
      end
      CMD_CCF, CMD_SCF: begin
        n_model = 1'b0;
        h_model = 1'b0;
        c_model = (cmd == CMD_SCF) ? 1'b1 : ~c_model;
      end
      CMD_LOAD: begin
        res = op;
        acc_model = op;
      end
      default: ;
    endcase
    out.result     = res;
    out.zero       = z_model;
    out.subtract   = n_model;
    out.half_carry = h_model;
    out.carry      = c_model;
    return out;
  endfunction

  task automatic queue_word(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] op);
    alu_word_t w;
    w.command = cmd;
    w.operand = op;
    pending_words.push_back(w);
  endtask

  initial begin
    logic [CmdW-1:0]  cmd;
    logic [DataW-1:0] op;
    int unsigned      target;
    queue_word(CMD_LOAD, 8'h00);
    queue_word(CMD_ADD,  8'h00);
    queue_word(CMD_LOAD, 8'hFF);
    queue_word(CMD_ADD,  8'h01);
    queue_word(CMD_ADC,  8'h00);
    queue_word(CMD_LOAD, 8'h0F);
    queue_word(CMD_ADC,  8'h01);
    queue_word(CMD_SUB,  8'h20);
    queue_word(CMD_SBC,  8'h0F);
    queue_word(CMD_CP,   8'hE0);
    queue_word(CMD_AND,  8'h00);
    queue_word(CMD_OR,   8'hFF);
    queue_word(CMD_XOR,  8'hFF);
    queue_word(CMD_INC,  8'hFF);
    queue_word(CMD_INC,  8'h0F);
    queue_word(CMD_DEC,  8'h00);
    queue_word(CMD_DEC,  8'h01);
    queue_word(CMD_RLC,  8'h80);
    queue_word(CMD_RL,   8'h00);
    queue_word(CMD_RRC,  8'h01);
    queue_word(CMD_RR,   8'h00);
    queue_word(CMD_CPL,  8'hA5);
    queue_word(CMD_CCF,  8'h5A);
    queue_word(CMD_SCF,  8'hFF);
    queue_word(CmdUnknownHi, 8'hFF);
    queue_word(CmdUnknownLo, 8'h00);
    target = pending_words.size() + RandomWords;
    while (pending_words.size() < target) begin
      if ($urandom_range(99) < 5) begin
        cmd = CmdW'($urandom_range(int'(CmdUnknownHi), int'(CmdUnknownLo)));
      end else begin
        cmd = CmdW'($urandom_range(int'(CMD_LOAD)));
      end
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0: op = 8'h00;
          1: op = 8'hFF;
          2: op = 8'h0F;
          3: op = 8'hF0;
          4: op = 8'h80;
          default: op = 8'h01;
        endcase
      end else begin
        op = DataW'($urandom_range(255));
      end
      // pair a load with a matching operand to hit zero results
      if ($urandom_range(9) == 0) begin
        queue_word(CMD_LOAD, op);
        case ($urandom_range(2))
          0: cmd = CMD_SUB;
          1: cmd = CMD_CP;
          default: cmd = CMD_XOR;
        endcase
      end
      queue_word(cmd, op);
    end
    total_words = pending_words.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_outcomes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (n_accepted < total_words / 3) begin
      send_idle_pct = 7;
      recv_idle_pct = 72;
    end else if (n_accepted < 2 * total_words / 3) begin
      send_idle_pct = 72;
      recv_idle_pct = 7;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_outcomes.push_back(alu_execute(command_i, operand_i));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = pending_words.pop_front();
          in_valid_i <= 1'b1;
          command_i  <= next_word.command;
          operand_i  <= next_word.operand;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.result     = result_o;
        got.zero       = zero_flag_o;
        got.subtract   = subtract_flag_o;
        got.half_carry = half_carry_flag_o;
        got.carry      = carry_flag_o;
        if (expected_outcomes.size() == 0) begin
          n_errors = n_errors + 1;
          if (n_errors <= ReportMax) begin
            $display("unexpected word: result %h znhc %b%b%b%b", got.result, got.zero,
                     got.subtract, got.half_carry, got.carry);
          end
        end else begin
          want = expected_outcomes.pop_front();
          if (got.result !== want.result || got.zero !== want.zero ||
              got.subtract !== want.subtract || got.half_carry !== want.half_carry ||
              got.carry !== want.carry) begin
            n_errors = n_errors + 1;
            if (n_errors <= ReportMax) begin
              $display("mismatch: expected result %h znhc %b%b%b%b, got result %h znhc %b%b%b%b",
                       want.result, want.zero, want.subtract, want.half_carry, want.carry,
                       got.result, got.zero, got.subtract, got.half_carry, got.carry);
            end
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/calu_pkg.sv
hw/rtl/cpu_alu_8bit_with_flags.sv
sim/cpu_alu_8bit_with_flags_test.sv
